@@ src/mmc_pkg.sv @@
// Shared types and constants of the match model context unit.
package mmc_pkg;

  localparam int unsigned HASH_BITS_DEF = 16;
  localparam int unsigned BUF_BITS_DEF  = 16;
  localparam int unsigned MAX_MATCH_DEF = 62;

  localparam int unsigned BPOS_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned CODE_W = 6;
  localparam int unsigned CTX_W  = 14;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Upper-case ASCII range folded into the hashes.
  localparam logic [BYTE_W-1:0] ASCII_UPPER_LO = 8'd65;
  localparam logic [BYTE_W-1:0] ASCII_UPPER_HI = 8'd90;
  localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'd32;

  // Context code: short lengths keep full resolution, long ones are quartered.
  localparam logic [LEN_W-1:0]  LEN_SHORT_LIM = 6'd16;
  localparam logic [CODE_W-1:0] CODE_LONG_OFS = 6'd24;

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_HIST_WR = 13'b0000000000100,
    ST_DECIDE  = 13'b0000000001000,
    ST_CHECK2  = 13'b0000000010000,
    ST_TBL_RD  = 13'b0000000100000,
    ST_LOAD_MP = 13'b0000001000000,
    ST_VER_RD  = 13'b0000010000000,
    ST_VER_CMP = 13'b0000100000000,
    ST_TBL_WR1 = 13'b0001000000000,
    ST_TBL_WR2 = 13'b0010000000000,
    ST_PB_RD   = 13'b0100000000000,
    ST_OUT     = 13'b1000000000000
  } mmc_state_e;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic hist_wr;
    logic extend;
    logic tbl_rd;
    logic tbl_wr;
    logic tbl_sel;     // 0: first hash, 1: second hash
    logic mp_load;
    logic ver_rd;
    logic ver_inc;
    logic len_from_n;
    logic pb_rd;
    logic out_load;
  } mmc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic bpos_zero;
    logic len_nz;
    logic len_lt2;
    logic ver_end;
    logic ver_eq;
    logic out_free;
  } mmc_stat_t;

endpackage

@@ src/mmc_ctrl.sv @@
// Sequencer of the match model context unit.
module mmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mmc_pkg::mmc_stat_t stat_i,
  output mmc_pkg::mmc_cmd_t  cmd_o
);
  import mmc_pkg::*;

  mmc_state_e state_q, state_d;
  logic       second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    second_d   = second_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = stat_i.bpos_zero ? ST_HIST_WR : ST_PB_RD;
        end
      end
      ST_HIST_WR: begin
        cmd_o.hist_wr = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.len_nz) begin
          cmd_o.extend = 1'b1;
          state_d = ST_CHECK2;
        end else begin
          second_d = 1'b0;
          state_d  = ST_TBL_RD;
        end
      end
      ST_CHECK2: begin
        if (stat_i.len_lt2) begin
          second_d = 1'b1;
          state_d  = ST_TBL_RD;
        end else begin
          state_d = ST_TBL_WR1;
        end
      end
      ST_TBL_RD: begin
        cmd_o.tbl_rd  = 1'b1;
        cmd_o.tbl_sel = second_q;
        state_d = ST_LOAD_MP;
      end
      ST_LOAD_MP: begin
        cmd_o.mp_load = 1'b1;
        state_d = ST_VER_RD;
      end
      ST_VER_RD: begin
        if (stat_i.ver_end) begin
          cmd_o.len_from_n = 1'b1;
          state_d = second_q ? ST_TBL_WR1 : ST_CHECK2;
        end else begin
          cmd_o.ver_rd = 1'b1;
          state_d = ST_VER_CMP;
        end
      end
      ST_VER_CMP: begin
        if (stat_i.ver_eq) begin
          cmd_o.ver_inc = 1'b1;
          state_d = ST_VER_RD;
        end else begin
          cmd_o.len_from_n = 1'b1;
          state_d = second_q ? ST_TBL_WR1 : ST_CHECK2;
        end
      end
      ST_TBL_WR1: begin
        cmd_o.tbl_wr  = 1'b1;
        cmd_o.tbl_sel = 1'b0;
        state_d = ST_TBL_WR2;
      end
      ST_TBL_WR2: begin
        cmd_o.tbl_wr  = 1'b1;
        cmd_o.tbl_sel = 1'b1;
        state_d = ST_PB_RD;
      end
      ST_PB_RD: begin
        cmd_o.pb_rd = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ src/mmc_dpath.sv @@
// Datapath of the match model context unit: history, hash table, hashes, match state.
module mmc_dpath #(
  parameter int unsigned HASH_BITS = mmc_pkg::HASH_BITS_DEF,
  parameter int unsigned BUF_BITS  = mmc_pkg::BUF_BITS_DEF,
  parameter int unsigned MAX_MATCH = mmc_pkg::MAX_MATCH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mmc_pkg::BPOS_W-1:0]       in_bpos_i,
  input  logic [mmc_pkg::BYTE_W-1:0]       in_part_i,
  input  logic [mmc_pkg::BYTE_W-1:0]       in_byte_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [mmc_pkg::CTX_W-1:0]        out_ctx_o,
  output logic [mmc_pkg::LEN_W-1:0]        out_len_o,
  input  mmc_pkg::mmc_cmd_t                cmd_i,
  output mmc_pkg::mmc_stat_t               stat_o
);
  import mmc_pkg::*;

  localparam int unsigned CLR_BITS = (HASH_BITS > BUF_BITS) ? HASH_BITS : BUF_BITS;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MATCH);

  logic [BYTE_W-1:0]   hist_mem [2**BUF_BITS];
  logic [BUF_BITS-1:0] tbl_mem  [2**HASH_BITS];

  logic [CLR_BITS-1:0]  clr_q;
  logic [BUF_BITS-1:0]  wp_q, mp_q;
  logic [LEN_W-1:0]     len_q, n_q;
  logic [HASH_BITS-1:0] h1_q, h2_q;
  logic [BYTE_W-1:0]    prev_q;
  logic                 out_valid_q;

  logic [BPOS_W-1:0]    bpos_q;
  logic [BYTE_W-1:0]    part_q, byte_q;
  logic [BYTE_W-1:0]    ra_q, rb_q;
  logic [BUF_BITS-1:0]  tq_q;
  logic [CTX_W-1:0]     ctx_q;
  logic [LEN_W-1:0]     olen_q;

  logic [BYTE_W-1:0]    hb;
  logic [BUF_BITS-1:0]  n_ext, va, vb;
  logic [BUF_BITS-1:0]  hist_waddr, ra_addr;
  logic [BYTE_W-1:0]    hist_wdata;
  logic [HASH_BITS-1:0] tbl_addr;
  logic [BUF_BITS-1:0]  tbl_wdata;
  logic                 hist_we, tbl_we;

  logic [BYTE_W:0]      pb_shift;
  logic                 pb_eq, pb_bit, hit;
  logic [CODE_W-1:0]    code;
  logic [CTX_W-1:0]     ctx_d;
  logic [LEN_W-1:0]     len_after;

  // hash byte: fold capitals to lowercase
  always_comb begin
    hb = byte_q;
    if (byte_q >= ASCII_UPPER_LO && byte_q <= ASCII_UPPER_HI) hb = byte_q + ASCII_CASE_OFS;
  end

  assign n_ext = BUF_BITS'(n_q);
  assign va    = mp_q - n_ext - BUF_BITS'(1);
  assign vb    = wp_q - n_ext - BUF_BITS'(1);

  assign hist_we    = cmd_i.clr_wr | cmd_i.hist_wr;
  assign hist_waddr = cmd_i.clr_wr ? clr_q[BUF_BITS-1:0] : wp_q;
  assign hist_wdata = cmd_i.clr_wr ? '0 : byte_q;
  assign ra_addr    = cmd_i.ver_rd ? va : mp_q;

  assign tbl_we    = cmd_i.clr_wr | cmd_i.tbl_wr;
  assign tbl_addr  = cmd_i.clr_wr ? clr_q[HASH_BITS-1:0] : (cmd_i.tbl_sel ? h2_q : h1_q);
  assign tbl_wdata = cmd_i.clr_wr ? '0 : wp_q;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (cmd_i.ver_rd | cmd_i.pb_rd) ra_q <= hist_mem[ra_addr];
    if (cmd_i.ver_rd) rb_q <= hist_mem[vb];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
    if (cmd_i.tbl_rd) tq_q <= tbl_mem[tbl_addr];
  end

  // predicted byte check and context
  assign pb_shift = {1'b1, ra_q} >> (4'd8 - {1'b0, bpos_q});
  assign pb_eq    = (pb_shift == {1'b0, part_q});
  assign pb_bit   = ra_q[3'd7 - bpos_q];
  assign hit      = (len_q != '0) && pb_eq;

  always_comb begin
    if (len_q < LEN_SHORT_LIM) code = {len_q[CODE_W-2:0], pb_bit};
    else                       code = {1'b0, len_q[LEN_W-1:2], pb_bit} + CODE_LONG_OFS;
    ctx_d     = hit ? {code, prev_q} : CTX_W'(part_q);
    len_after = hit ? len_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      wp_q        <= '0;
      mp_q        <= '0;
      len_q       <= '0;
      n_q         <= '0;
      h1_q        <= '0;
      h2_q        <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + CLR_BITS'(1);
      if (cmd_i.hist_wr) begin
        wp_q   <= wp_q + BUF_BITS'(1);
        prev_q <= byte_q;
        h1_q   <= (h1_q << 4) + (h1_q << 3) + HASH_BITS'(hb);
        h2_q   <= (h2_q << 7) + (h2_q << 5) + HASH_BITS'(hb);
      end
      if (cmd_i.extend) begin
        mp_q <= mp_q + BUF_BITS'(1);
        if (len_q < MAX_LEN) len_q <= len_q + LEN_W'(1);
      end
      if (cmd_i.mp_load) begin
        mp_q <= tq_q;
        n_q  <= '0;
      end
      if (cmd_i.ver_inc) n_q <= n_q + LEN_W'(1);
      if (cmd_i.len_from_n) len_q <= n_q;
      if (cmd_i.out_load) begin
        len_q       <= len_after;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      bpos_q <= in_bpos_i;
      part_q <= in_part_i;
      byte_q <= in_byte_i;
    end
    if (cmd_i.out_load) begin
      ctx_q  <= ctx_d;
      olen_q <= len_after;
    end
  end

  always_comb begin
    stat_o.clr_done  = &clr_q;
    stat_o.bpos_zero = (in_bpos_i == '0);
    stat_o.len_nz    = (len_q != '0);
    stat_o.len_lt2   = (len_q < LEN_W'(2));
    // stop on self match, full length, or reaching the write position
    stat_o.ver_end   = (mp_q == wp_q) || (n_q == MAX_LEN) || (va == wp_q);
    stat_o.ver_eq    = (ra_q == rb_q);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_ctx_o   = ctx_q;
  assign out_len_o   = olen_q;

endmodule

@@ src/match_model_context_unit.sv @@
// Top level of the match model context unit.
//
// One input transaction per coded bit on the s_axis channel: bit position,
// partial byte with leading one and, at a byte boundary, the completed byte.
// Each input transaction yields exactly one output transaction on m_axis with
// the match context and the verified match length.
//
// Work per item: a bit inside a byte is accepted, the predicted byte is read
// from the history, and the context is built. A byte boundary adds the history
// write, up to two hash table lookups and two table writes; each lookup verifies
// the candidate backwards over the single history buffer, one byte per read and
// compare. The second lookup runs only when the first verified fewer than two
// bytes, and no lookup verifies more than MAX_MATCH bytes.
// One item is in work at a time; s_axis_tready_o is high only between items.
//
// After reset both stores are cleared, one entry a cycle, until every address
// of the larger one has been written; no input is taken until then.
// A result sits in the output register until m_axis_tready_i; the next item
// may be accepted and worked on meanwhile and waits only to deliver its result.
module match_model_context_unit #(
  parameter int unsigned HASH_BITS = mmc_pkg::HASH_BITS_DEF,
  parameter int unsigned BUF_BITS  = mmc_pkg::BUF_BITS_DEF,
  parameter int unsigned MAX_MATCH = mmc_pkg::MAX_MATCH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [2:0] bit_position, [10:3] partial_byte, [18:11] last_byte, [23:19] zero
  input  logic [mmc_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [13:0] context_res, [19:14] match_length_out, [23:20] zero
  output logic [mmc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import mmc_pkg::*;

  mmc_cmd_t          cmd;
  mmc_stat_t         stat;
  logic [CTX_W-1:0]  out_ctx;
  logic [LEN_W-1:0]  out_len;

  mmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmc_dpath #(
    .HASH_BITS (HASH_BITS),
    .BUF_BITS  (BUF_BITS),
    .MAX_MATCH (MAX_MATCH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_bpos_i   (s_axis_tdata_i[2:0]),
    .in_part_i   (s_axis_tdata_i[10:3]),
    .in_byte_i   (s_axis_tdata_i[18:11]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ctx_o   (out_ctx),
    .out_len_o   (out_len),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - CTX_W - LEN_W)'(0), out_len, out_ctx};

endmodule

@@ dv/match_model_context_unit_test.sv @@
// Self-checking testbench of the match model context unit: stimulus table, byte streams, predictor.
module match_model_context_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MATCH_CAP    = mmc_pkg::MAX_MATCH_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int IDLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES = 400;
  localparam int N_DIRECTED   = 24;

  localparam bit [7:0] CHAR_CAP_A   = 8'h41;
  localparam bit [7:0] CHAR_CAP_Z   = 8'h5A;
  localparam bit [7:0] CHAR_LOW_A   = 8'h61;
  localparam bit [7:0] CHAR_LOW_Z   = 8'h7A;
  localparam bit [7:0] CASE_FOLD    = 8'h20;

  typedef struct packed {
    bit [2:0]  bpos;
    bit [7:0]  part;
    bit [7:0]  last_b;
    bit        has_ref;
    bit [13:0] ref_ctx;
    bit [5:0]  ref_len;
  } coded_bit_t;

  typedef struct packed {
    bit [13:0] ctx;
    bit [5:0]  len;
  } ctx_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic [mmc_pkg::IN_TDATA_W-1:0] s_data = '0;
  logic                           rcv_ready = 1'b0;
  logic                           s_ready;
  logic                           m_valid;
  logic [mmc_pkg::OUT_TDATA_W-1:0] m_data;

  match_model_context_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (rcv_ready),
    .m_axis_tdata_o  (m_data)
  );

  // Predictor state
  bit [15:0] pos_table [0:65535];
  bit [7:0]  byte_hist [0:65535];
  bit [15:0] wr_pos;
  bit [15:0] match_ptr;
  bit [5:0]  run_len;
  bit [15:0] hash_a;
  bit [15:0] hash_b;

  coded_bit_t  coded_bits_q [$];
  ctx_result_t expected_ctx_q [$];
  bit [7:0]    src_hist [$];
  bit [7:0]    prev_src;
  int          n_fail = 0;

  // Directed rows: bpos, partial, last byte, typed-in flag, context, length.
  coded_bit_t directed_tbl [N_DIRECTED] = '{
    {3'd0, 8'd1,   8'h00, 1'b1, 14'd13824, 6'd62},  // zero history matches to the cap
    {3'd1, 8'd0,   8'h00, 1'b1, 14'd0,     6'd0},   // partial byte of zero breaks it
    {3'd7, 8'd255, 8'hFF, 1'b1, 14'd255,   6'd0},
    {3'd0, 8'd1,   8'hFF, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   CHAR_CAP_A, 1'b0, 14'd0, 6'd0},
    {3'd0, 8'd1,   CHAR_CAP_Z, 1'b0, 14'd0, 6'd0},
    {3'd0, 8'd1,   8'h40, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   8'h5B, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   CHAR_LOW_A, 1'b0, 14'd0, 6'd0},
    {3'd0, 8'd1,   CHAR_LOW_Z, 1'b0, 14'd0, 6'd0},
    {3'd0, 8'd1,   CHAR_CAP_A, 1'b0, 14'd0, 6'd0},
    {3'd0, 8'd1,   CHAR_CAP_Z, 1'b0, 14'd0, 6'd0},
    {3'd1, 8'd2,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd4, 8'd21,  8'h00, 1'b0, 14'd0,     6'd0},
    {3'd7, 8'd173, 8'h00, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd0,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd255, 8'h80, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd0, 8'd1,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd2, 8'd4,   8'h00, 1'b0, 14'd0,     6'd0},
    {3'd5, 8'd32,  8'h00, 1'b0, 14'd0,     6'd0},
    {3'd6, 8'd64,  8'h7F, 1'b0, 14'd0,     6'd0},
    {3'd3, 8'd15,  8'h01, 1'b0, 14'd0,     6'd0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Count matching history bytes backwards from a candidate position.
  function automatic bit [5:0] count_backward(input bit [15:0] cand);
    bit [5:0]  n;
    bit [15:0] a;
    bit [15:0] b;
    bit        stop;
    n = 6'd0;
    stop = 1'b0;
    if (cand == wr_pos) return 6'd0;
    while (!stop && n < MATCH_CAP) begin
      a = cand - {10'd0, n} - 16'd1;
      b = wr_pos - {10'd0, n} - 16'd1;
      if (a == wr_pos || byte_hist[a] != byte_hist[b]) begin
        stop = 1'b1;
      end else begin
        n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic void predict_context(input bit [2:0] bpos, input bit [7:0] part,
                                          input bit [7:0] last_b,
                                          output bit [13:0] ctx, output bit [5:0] len);
    bit [7:0]  hb;
    bit [7:0]  pb;
    bit [8:0]  lead;
    bit [5:0]  code;
    bit [15:0] prev_pos;
    bit        pbit;
    ctx = {6'd0, part};
    if (bpos == 3'd0) begin
      byte_hist[wr_pos] = last_b;
      wr_pos = wr_pos + 16'd1;
      hb = last_b;
      if (hb >= CHAR_CAP_A && hb <= CHAR_CAP_Z) hb = hb + CASE_FOLD;
      hash_a = hash_a * 16'd24 + {8'd0, hb};
      hash_b = hash_b * 16'd160 + {8'd0, hb};
      if (run_len > 6'd0) begin
        match_ptr = match_ptr + 16'd1;
        if (run_len < MATCH_CAP) run_len = run_len + 6'd1;
      end else begin
        match_ptr = pos_table[hash_a];
        run_len = count_backward(match_ptr);
      end
      if (run_len < 6'd2) begin
        match_ptr = pos_table[hash_b];
        run_len = count_backward(match_ptr);
      end
      pos_table[hash_a] = wr_pos;
      pos_table[hash_b] = wr_pos;
    end
    if (run_len > 6'd0) begin
      pb = byte_hist[match_ptr];
      lead = {1'b1, pb} >> (4'd8 - {1'b0, bpos});
      if (lead == {1'b0, part}) begin
        pbit = pb[3'd7 - bpos];
        if (run_len < 6'd16) code = {run_len[4:0], pbit};
        else code = {1'b0, run_len[5:2], pbit} + 6'd24;
        prev_pos = wr_pos - 16'd1;
        ctx = {code, byte_hist[prev_pos]};
      end else begin
        run_len = 6'd0;
      end
    end
    len = run_len;
  endfunction

  function automatic bit [7:0] pick_byte();
    bit [7:0] v;
    case ($urandom_range(0, 3))
      0: v = CHAR_CAP_A + 8'($urandom_range(0, 3));
      1: v = CHAR_LOW_A + 8'($urandom_range(0, 3));
      2: v = 8'($urandom_range(0, 255));
      default: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
    return v;
  endfunction

  // Queue the bits of one byte; the boundary item carries the byte before it.
  task automatic push_coded_byte(input bit [7:0] b, input int nbits);
    coded_bit_t it;
    bit [8:0]   lead;
    for (int k = 0; k < nbits; k++) begin
      it = '0;
      it.bpos = 3'(k);
      lead = {1'b1, b} >> (8 - k);
      it.part = (k == 0) ? 8'd1 : lead[7:0];
      it.last_b = (k == 0) ? prev_src : 8'($urandom_range(0, 255));
      coded_bits_q.push_back(it);
    end
    src_hist.push_back(b);
    prev_src = b;
  endtask

  initial begin : stim_driver
    int         idx;
    int         burst_left;
    int         gap;
    int         run_bytes;
    int         period;
    int         start;
    int         cnt;
    bit [7:0]   pattern [8];
    bit [7:0]   b;
    coded_bit_t it;
    bit [13:0]  exp_ctx;
    bit [5:0]   exp_len;

    for (int i = 0; i < 65536; i++) begin
      pos_table[i] = 16'd0;
      byte_hist[i] = 8'd0;
    end
    wr_pos = 16'd0;
    match_ptr = 16'd0;
    run_len = 6'd0;
    hash_a = 16'd0;
    hash_b = 16'd0;

    foreach (directed_tbl[i]) coded_bits_q.push_back(directed_tbl[i]);
    prev_src = 8'h00;

    // Periodic run that drives the match length up towards its cap.
    period = $urandom_range(3, 8);
    for (int i = 0; i < period; i++) pattern[i] = pick_byte();
    run_bytes = $urandom_range(66, 72);
    for (int i = 0; i < run_bytes; i++) push_coded_byte(pattern[i % period], 8);

    while (coded_bits_q.size() < N_DIRECTED + RANDOM_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          // repeat an earlier phrase, now and then with a flipped case or a stray byte
          start = $urandom_range(0, src_hist.size() - 1);
          cnt = $urandom_range(2, 24);
          for (int i = 0; i < cnt && start + i < src_hist.size(); i++) begin
            b = src_hist[start + i];
            if ($urandom_range(0, 15) == 0) begin
              if ((b >= CHAR_CAP_A && b <= CHAR_CAP_Z) || (b >= CHAR_LOW_A && b <= CHAR_LOW_Z))
                b = b ^ CASE_FOLD;
              else
                b = pick_byte();
            end
            push_coded_byte(b, 8);
          end
        end
        [45:74]: begin
          cnt = $urandom_range(1, 6);
          for (int i = 0; i < cnt; i++) push_coded_byte(pick_byte(), 8);
        end
        [75:87]: push_coded_byte(pick_byte(), $urandom_range(1, 7));
        default: begin
          cnt = $urandom_range(1, 4);
          for (int i = 0; i < cnt; i++) begin
            it = '0;
            it.bpos = 3'($urandom_range(0, 7));
            it.part = 8'($urandom_range(0, 255));
            it.last_b = 8'($urandom_range(0, 255));
            coded_bits_q.push_back(it);
          end
        end
      endcase
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    idx = 0;
    burst_left = 0;
    while (idx < coded_bits_q.size()) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      it = coded_bits_q[idx];
      s_data <= {5'd0, it.last_b, it.part, it.bpos};
      s_valid <= 1'b1;
      @(posedge clk_i);
      while (!s_ready) @(posedge clk_i);
      predict_context(it.bpos, it.part, it.last_b, exp_ctx, exp_len);
      if (it.has_ref) begin
        exp_ctx = it.ref_ctx;
        exp_len = it.ref_len;
      end
      expected_ctx_q.push_back({exp_ctx, exp_len});
      idx++;
      burst_left--;
    end
    s_valid <= 1'b0;

    while (expected_ctx_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver stalls: phases of always ready, coin flip, and mostly stalled.
  int stall_mode = 0;
  int stall_phase_left = 0;
  always @(posedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase_left = $urandom_range(20, 200);
    end
    stall_phase_left--;
    case (stall_mode)
      0: rcv_ready <= 1'b1;
      1: rcv_ready <= 1'($urandom_range(0, 1));
      default: rcv_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    ctx_result_t exp_r;
    if (rst_ni && m_valid && rcv_ready) begin
      if (expected_ctx_q.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", m_data);
        n_fail++;
      end else begin
        exp_r = expected_ctx_q.pop_front();
        if (m_data[13:0] !== exp_r.ctx) begin
          $error("context_res: expected %0d, got %0d", exp_r.ctx, m_data[13:0]);
          n_fail++;
        end
        if (m_data[19:14] !== exp_r.len) begin
          $error("match_length_out: expected %0d, got %0d", exp_r.len, m_data[19:14]);
          n_fail++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && rcv_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $error("no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
